>>> rtl/obcdm_pkg.sv
// Shared types, constants and the quarter-wave sine table for the
// omni ball-chase drive mixer. No dependencies.
package obcdm_pkg;

  // default fixed-point settings
  localparam int ANGLE_FRAC_BITS_DEF = 4;
  localparam int SINE_BITS_DEF       = 16;

  // pipeline shape and queue sizes
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 5;
  localparam int MID_DEPTH    = FRONT_STAGES + 2;
  localparam int OUT_DEPTH    = BACK_STAGES + 2;

  // x/45 by reciprocal, exact for x below SAT_LEVEL
  localparam int DIV45_MUL = 11651;
  localparam int DIV45_SH  = 19;
  localparam int SAT_LEVEL = 5760;  // 128 * 45

  typedef enum logic [1:0] {
    MODE_LINE  = 2'd0,
    MODE_CHASE = 2'd1,
    MODE_OTHER = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_DRIVE_MAG    = 3'd0,
    REG_FRONT_WIN    = 3'd1,
    REG_OFFSET_FAR   = 3'd2,
    REG_OFFSET_NEAR  = 3'd3,
    REG_HEADING_GAIN = 3'd4,
    REG_DEADBAND     = 3'd5,
    REG_LINE_LEVEL   = 3'd6,
    REG_NEAR_LEVEL   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] drive_magnitude;
    logic [6:0] front_window_deg;
    logic [7:0] offset_far_deg;
    logic [7:0] offset_near_deg;
    logic [6:0] heading_gain;
    logic [9:0] heading_deadband_tenths;
    logic [9:0] line_absent_level;
    logic [9:0] near_ball_level;
  } cfg_t;

  typedef struct packed {
    logic [9:0] ball_angle;
    logic [9:0] ball_proximity;
    logic [9:0] heading;
    logic [9:0] line_angle;
  } in_t;

  typedef struct packed {
    logic [7:0] motor_a;
    logic [7:0] motor_b;
    logic [7:0] motor_c;
    logic [7:0] motor_d;
    mode_t      mode;
  } out_t;

  // classification handed from front to back
  typedef struct packed {
    mode_t              mode;
    logic               vec;   // rotated vector from direction
    logic               zero;  // translation forced to zero
    logic signed [10:0] err;   // heading error, degrees
  } job_t;

  // Q1.15 sine at whole degrees, 0..90
  function automatic logic [15:0] qsine(input logic [6:0] k);
    case (k)
      7'd0:  return 16'd0;     7'd1:  return 16'd572;   7'd2:  return 16'd1144;
      7'd3:  return 16'd1715;  7'd4:  return 16'd2286;  7'd5:  return 16'd2856;
      7'd6:  return 16'd3425;  7'd7:  return 16'd3993;  7'd8:  return 16'd4560;
      7'd9:  return 16'd5126;  7'd10: return 16'd5690;  7'd11: return 16'd6252;
      7'd12: return 16'd6813;  7'd13: return 16'd7371;  7'd14: return 16'd7927;
      7'd15: return 16'd8481;  7'd16: return 16'd9032;  7'd17: return 16'd9580;
      7'd18: return 16'd10126; 7'd19: return 16'd10668; 7'd20: return 16'd11207;
      7'd21: return 16'd11743; 7'd22: return 16'd12275; 7'd23: return 16'd12803;
      7'd24: return 16'd13328; 7'd25: return 16'd13848; 7'd26: return 16'd14365;
      7'd27: return 16'd14876; 7'd28: return 16'd15384; 7'd29: return 16'd15886;
      7'd30: return 16'd16384; 7'd31: return 16'd16877; 7'd32: return 16'd17364;
      7'd33: return 16'd17847; 7'd34: return 16'd18324; 7'd35: return 16'd18795;
      7'd36: return 16'd19261; 7'd37: return 16'd19720; 7'd38: return 16'd20174;
      7'd39: return 16'd20622; 7'd40: return 16'd21063; 7'd41: return 16'd21498;
      7'd42: return 16'd21926; 7'd43: return 16'd22348; 7'd44: return 16'd22763;
      7'd45: return 16'd23170; 7'd46: return 16'd23571; 7'd47: return 16'd23965;
      7'd48: return 16'd24351; 7'd49: return 16'd24730; 7'd50: return 16'd25102;
      7'd51: return 16'd25466; 7'd52: return 16'd25822; 7'd53: return 16'd26170;
      7'd54: return 16'd26510; 7'd55: return 16'd26842; 7'd56: return 16'd27166;
      7'd57: return 16'd27482; 7'd58: return 16'd27789; 7'd59: return 16'd28088;
      7'd60: return 16'd28378; 7'd61: return 16'd28660; 7'd62: return 16'd28932;
      7'd63: return 16'd29197; 7'd64: return 16'd29452; 7'd65: return 16'd29698;
      7'd66: return 16'd29935; 7'd67: return 16'd30163; 7'd68: return 16'd30382;
      7'd69: return 16'd30592; 7'd70: return 16'd30792; 7'd71: return 16'd30983;
      7'd72: return 16'd31164; 7'd73: return 16'd31336; 7'd74: return 16'd31499;
      7'd75: return 16'd31651; 7'd76: return 16'd31795; 7'd77: return 16'd31928;
      7'd78: return 16'd32052; 7'd79: return 16'd32166; 7'd80: return 16'd32270;
      7'd81: return 16'd32365; 7'd82: return 16'd32448; 7'd83: return 16'd32523;
      7'd84: return 16'd32587; 7'd85: return 16'd32643; 7'd86: return 16'd32691;
      7'd87: return 16'd32723; 7'd88: return 16'd32748; 7'd89: return 16'd32763;
      default: return 16'd32768;
    endcase
  endfunction

endpackage

>>> rtl/obcdm_fifo.sv
// Small synchronous queue of any packed type, register storage.
// No dependencies.
module obcdm_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  T     wdata,
  input  logic rd,
  output T     rdata,
  output logic empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

>>> rtl/obcdm_front.sv
// Front end: classifies a sample (mode, flags, heading error) and works out
// the travel direction, with the curve offset divide. Uses obcdm_pkg.
module obcdm_front #(
  parameter int ANGLE_FRAC_BITS = obcdm_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int DIR_W           = 12 + ANGLE_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  obcdm_pkg::in_t       sample,
  input  obcdm_pkg::cfg_t      cfg,
  output logic                 out_valid,
  output obcdm_pkg::job_t      out_ctl,
  output logic [DIR_W-1:0]     out_dir
);
  localparam int AF     = ANGLE_FRAC_BITS;
  localparam int AS     = 1 << AF;
  localparam int CHASE  = (405 * AS) / 2;
  localparam int NW     = 24 + AF;      // rounded numerator
  localparam int MW     = NW - 4;       // numerator over 16
  localparam int K      = MW + 11;
  localparam longint unsigned RECIP = (64'd1 << K) / 2025;
  localparam int RW     = MW + 1;
  localparam int QW     = MW - 10;

  typedef struct packed {
    obcdm_pkg::job_t  ctl;
    logic [DIR_W-1:0] base;
    logic             curve;
    logic             sub;
    logic             dpos;
    logic [7:0]       near;
  } st_t;

  st_t s1, s2, s3, s4;
  logic [3:0] vld;
  logic [7:0]  s1_dabs;
  logic [14:0] s1_pabs;
  logic [MW-1:0] s2_m, s3_m;
  logic [QW-1:0] s3_q0;
  logic [DIR_W-1:0] s4_dir;

  // stage 1: classification
  logic [9:0]  b, p, h, l;
  logic [12:0] b5, fw6;
  logic [13:0] h10;
  logic        ahead, chase, band, noball, line_on, tilt, dz;
  logic [18:0] pprod;
  st_t         c1;

  always_comb begin
    b = sample.ball_angle;
    p = sample.ball_proximity;
    h = sample.heading;
    l = sample.line_angle;
    line_on = l < cfg.line_absent_level;
    tilt    = (h > 10'd50) && (h < 10'd310) && (l > cfg.line_absent_level);
    b5      = 13'(b) * 13'd5;
    fw6     = 13'(cfg.front_window_deg) * 13'd6;
    ahead   = (b5 < fw6) || ((b5 + fw6 > 13'd1800) && (b < 10'd360));
    chase   = (p < cfg.near_ball_level) || ahead;
    band    = (b > 10'(cfg.front_window_deg)) &&
              (11'(b) + 11'(cfg.front_window_deg) < 11'd360);
    noball  = b > 10'd409;
    h10     = 14'(h) * 14'd10;
    dz      = (h10 < 14'(cfg.heading_deadband_tenths)) ||
              (h10 + 14'(cfg.heading_deadband_tenths) > 14'd3600);
    pprod   = 19'(b) * 19'(9'(10'd360 - b));

    c1.ctl.err  = dz ? 11'sd0 :
                  (h < 10'd180) ? $signed(11'(h)) : $signed(11'(h)) - 11'sd360;
    c1.near     = cfg.offset_near_deg;
    c1.dpos     = cfg.offset_near_deg > cfg.offset_far_deg;
    c1.sub      = b >= 10'd180;
    c1.curve    = 1'b0;
    c1.ctl.vec  = 1'b1;
    c1.ctl.zero = tilt;
    c1.base     = DIR_W'(DIR_W'(b) << AF) + DIR_W'(CHASE);
    if (line_on) begin
      c1.ctl.mode = obcdm_pkg::MODE_LINE;
      c1.base     = DIR_W'(DIR_W'(11'(l) + 11'd180) << AF);
    end else if (chase) begin
      c1.ctl.mode = obcdm_pkg::MODE_CHASE;
    end else begin
      c1.ctl.mode = obcdm_pkg::MODE_OTHER;
      c1.curve    = band;
      c1.ctl.vec  = band;
      c1.ctl.zero = tilt || (!band && noball);
    end
  end

  // stage 2: rounded numerator |d| * b*(360-b) * 2^AF + 16200, over 16
  logic [22:0]   t;
  logic [NW-1:0] n;
  always_comb begin
    t = 23'(s1_dabs) * 23'(s1_pabs);
    n = (NW'(t) << AF) + NW'(16200);
  end

  // stage 3: quotient estimate by reciprocal
  logic [MW+RW-1:0] prod;
  assign prod = (MW + RW)'(s2_m) * (MW + RW)'(RECIP);

  // stage 4: one correction step, then offset and direction
  logic [MW-1:0]          rem;
  logic [QW-1:0]          q;
  logic signed [DIR_W-1:0] alpha, delta;
  always_comb begin
    rem   = s3_m - MW'(MW'(s3_q0) * MW'(2025));
    q     = (rem >= MW'(2025)) ? s3_q0 + 1'b1 : s3_q0;
    alpha = $signed(DIR_W'(DIR_W'(s3.near) << AF));
    alpha = s3.dpos ? alpha - $signed(DIR_W'(q)) : alpha + $signed(DIR_W'(q));
    delta = s3.sub ? -alpha : alpha;
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1      <= c1;
    s1_dabs <= c1.dpos ? cfg.offset_near_deg - cfg.offset_far_deg
                       : cfg.offset_far_deg - cfg.offset_near_deg;
    s1_pabs <= pprod[14:0];
    s2      <= s1;
    s2_m    <= MW'(n >> 4);
    s3      <= s2;
    s3_m    <= s2_m;
    s3_q0   <= QW'(prod >> K);
    s4      <= s3;
    s4_dir  <= s3.curve ? DIR_W'($signed(s3.base) + delta) : s3.base;
  end

  assign out_valid = vld[3];
  assign out_ctl   = s4.ctl;
  assign out_dir   = s4_dir;
endmodule

>>> rtl/obcdm_back.sv
// Back end: sine and cosine of the direction, scaling, wheel mixing and
// sign-magnitude encoding. Uses obcdm_pkg.
module obcdm_back #(
  parameter int ANGLE_FRAC_BITS = obcdm_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int SINE_BITS       = obcdm_pkg::SINE_BITS_DEF,
  parameter int DIR_W           = 12 + ANGLE_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  obcdm_pkg::job_t  in_ctl,
  input  logic [DIR_W-1:0] in_dir,
  input  obcdm_pkg::cfg_t  cfg,
  output logic             out_valid,
  output obcdm_pkg::out_t  result
);
  localparam int AF     = ANGLE_FRAC_BITS;
  localparam int SB     = SINE_BITS;
  localparam int AS     = 1 << AF;
  localparam int FT     = 360 * AS;
  localparam int QT     = 90 * AS;
  localparam int SFRAC  = SB - 1;
  localparam int UW     = 9 + AF;
  localparam int PW     = 11 + AF;
  localparam int UP_SH  = (SB >= 16) ? SB - 16 : 0;
  localparam int DN_SH  = (SB < 16) ? 16 - SB : 0;
  localparam int DN_RND = (DN_SH > 0) ? (1 << (DN_SH - 1)) : 0;
  localparam int IW     = ((SB > 16) ? SB : 16) + 2;
  localparam int XW     = SB + 9;
  localparam int NUMW   = SB + 18;

  // reduce a non-negative angle below one full turn
  function automatic logic [UW-1:0] wrap_turn(input logic [DIR_W-1:0] v);
    logic [UW-1:0] res;
    res = UW'(v);
    for (int k = 1; k < 6; k++) begin
      if (v >= DIR_W'(k * FT)) begin
        res = UW'(v - DIR_W'(k * FT));
      end
    end
    return res;
  endfunction

  // interpolated sine of an angle in [0, 360)
  function automatic logic signed [SB:0] sine_of(input logic [UW-1:0] u);
    logic [UW-1:0] r;
    logic          neg;
    logic [6:0]    k;
    logic [UW-1:0] f;
    logic [15:0]   t0, t1, m;
    logic [PW-1:0] ip;
    logic [IW-1:0] mr;
    logic [SB-1:0] ms;
    neg = 1'b0;
    r   = u;
    if (u >= UW'(3 * QT)) begin
      r   = UW'(4 * QT) - u;
      neg = 1'b1;
    end else if (u >= UW'(2 * QT)) begin
      r   = u - UW'(2 * QT);
      neg = 1'b1;
    end else if (u >= UW'(QT)) begin
      r = UW'(2 * QT) - u;
    end
    k  = 7'(r >> AF);
    f  = r & UW'(AS - 1);
    t0 = obcdm_pkg::qsine(k);
    t1 = obcdm_pkg::qsine(k + 7'd1);
    ip = PW'(PW'(t1 - t0) * PW'(f)) + PW'(AS / 2);
    m  = (k >= 7'd90) ? t0 : t0 + 16'(ip >> AF);
    mr = ((IW'(m) + IW'(DN_RND)) >> DN_SH) << UP_SH;
    ms = SB'(mr);
    return neg ? -$signed({1'b0, ms}) : $signed({1'b0, ms});
  endfunction

  logic [4:0] vld;
  obcdm_pkg::job_t c1, c2, c3, c4;
  logic [UW-1:0]          s1_us, s1_uc;
  logic signed [SB:0]     s2_sin, s2_cos;
  logic signed [XW-1:0]   s3_x, s3_y;
  logic signed [18:0]     s3_eg;
  logic [3:0]             s4_neg, s4_sat;
  logic [12:0]            s4_w [4];
  obcdm_pkg::out_t        s5;

  // stage 1: angle wrap for sine and cosine
  logic [DIR_W-1:0] vs, vc;
  always_comb begin
    vs = in_dir + DIR_W'(720 * AS);
    vc = in_dir + DIR_W'(810 * AS);
  end

  // stage 3: translation vector and heading term
  logic signed [XW-1:0] x_n, y_n;
  logic signed [XW-1:0] straight;
  always_comb begin
    straight = $signed(XW'(XW'(cfg.drive_magnitude) << SFRAC));
    if (c2.zero) begin
      x_n = '0;
      y_n = '0;
    end else if (c2.vec) begin
      x_n = s2_cos * $signed({1'b0, cfg.drive_magnitude});
      y_n = s2_sin * $signed({1'b0, cfg.drive_magnitude});
    end else begin
      x_n = straight;
      y_n = straight;
    end
  end

  // stage 4: wheel sums, magnitude over 2^(SFRAC+2)
  logic signed [NUMW-1:0] xe, ye, x180, y180, egs;
  logic signed [NUMW-1:0] num [4];
  logic [NUMW-1:0]        mag [4];
  logic [NUMW-1:0]        w   [4];
  always_comb begin
    xe     = NUMW'(s3_x);
    ye     = NUMW'(s3_y);
    x180   = xe * $signed(NUMW'(180));
    y180   = ye * $signed(NUMW'(180));
    egs    = NUMW'(s3_eg) <<< SFRAC;
    num[0] = egs - x180;
    num[1] = egs + y180;
    num[2] = egs - y180;
    num[3] = egs + x180;
    for (int i = 0; i < 4; i++) begin
      mag[i] = num[i][NUMW-1] ? NUMW'(-num[i]) : NUMW'(num[i]);
      w[i]   = mag[i] >> (SFRAC + 2);
    end
  end

  // stage 5: divide by 45, saturate, encode
  logic [26:0] qp [4];
  logic [6:0]  m7 [4];
  logic [7:0]  enc [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qp[i]  = 27'(s4_w[i]) * 27'(obcdm_pkg::DIV45_MUL);
      m7[i]  = s4_sat[i] ? 7'd127 : 7'(qp[i] >> obcdm_pkg::DIV45_SH);
      enc[i] = {s4_neg[i] && (m7[i] != 7'd0), m7[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    c1     <= in_ctl;
    s1_us  <= wrap_turn(vs);
    s1_uc  <= wrap_turn(vc);
    c2     <= c1;
    s2_sin <= sine_of(s1_us);
    s2_cos <= sine_of(s1_uc);
    c3     <= c2;
    s3_x   <= x_n;
    s3_y   <= y_n;
    s3_eg  <= c2.err * $signed({1'b0, cfg.heading_gain});
    c4     <= c3;
    for (int i = 0; i < 4; i++) begin
      s4_neg[i] <= num[i][NUMW-1];
      s4_sat[i] <= w[i] >= NUMW'(obcdm_pkg::SAT_LEVEL);
      s4_w[i]   <= w[i][12:0];
    end
    s5.motor_a <= enc[0];
    s5.motor_b <= enc[1];
    s5.motor_c <= enc[2];
    s5.motor_d <= enc[3];
    s5.mode    <= c4.mode;
  end

  assign out_valid = vld[4];
  assign result    = s5;
endmodule

>>> rtl/omni_ball_chase_drive_mixer.sv
// Top level of the omni ball-chase drive mixer: configuration registers,
// front and back pipelines, queues and credit counters. Uses obcdm_pkg.
//
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------
// sample    | push / full                | obcdm_pkg::in_t
// result    | pop / empty                | obcdm_pkg::out_t
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One sample per cycle is taken while full is low; with no backlog a sample
// passes through 4 front stages, a mid queue write, 5 back stages and a
// result queue write.
// Both pipelines always advance; credit counters hold back samples when the
// mid queue or result queue would overflow, so a stalled pop only blocks
// input once the queues fill. Reset is synchronous and restores the
// register defaults; cfg_ready is always high.
module omni_ball_chase_drive_mixer #(
  parameter int ANGLE_FRAC_BITS = obcdm_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int SINE_BITS       = obcdm_pkg::SINE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  obcdm_pkg::in_t  sample,
  input  logic            pop,
  output logic            empty,
  output obcdm_pkg::out_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [9:0]      cfg_data
);
  localparam int DIR_W = 12 + ANGLE_FRAC_BITS;
  localparam int MCW   = $clog2(obcdm_pkg::MID_DEPTH + 1);
  localparam int OCW   = $clog2(obcdm_pkg::OUT_DEPTH + 1);

  typedef struct packed {
    obcdm_pkg::job_t  ctl;
    logic [DIR_W-1:0] dir;
  } mid_t;

  obcdm_pkg::cfg_t cfg;
  logic [MCW-1:0]  mid_cred;
  logic [OCW-1:0]  out_cred;
  logic            accept, mid_pop, out_pop;
  logic            front_valid, back_valid, mid_empty;
  obcdm_pkg::job_t front_ctl;
  logic [DIR_W-1:0] front_dir;
  mid_t            mid_in, mid_out;
  obcdm_pkg::out_t back_res;

  assign cfg_ready = 1'b1;
  assign full      = (mid_cred == MCW'(obcdm_pkg::MID_DEPTH));
  assign accept    = push && !full;
  assign mid_pop   = !mid_empty && (out_cred < OCW'(obcdm_pkg::OUT_DEPTH));
  assign out_pop   = pop && !empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_magnitude         <= 7'd80;
      cfg.front_window_deg        <= 7'd10;
      cfg.offset_far_deg          <= 8'd70;
      cfg.offset_near_deg         <= 8'd30;
      cfg.heading_gain            <= 7'd15;
      cfg.heading_deadband_tenths <= 10'd25;
      cfg.line_absent_level       <= 10'd400;
      cfg.near_ball_level         <= 10'd500;
    end else if (cfg_valid && cfg_ready) begin
      case (obcdm_pkg::reg_idx_t'(cfg_index))
        obcdm_pkg::REG_DRIVE_MAG:    cfg.drive_magnitude         <= cfg_data[6:0];
        obcdm_pkg::REG_FRONT_WIN:    cfg.front_window_deg        <= cfg_data[6:0];
        obcdm_pkg::REG_OFFSET_FAR:   cfg.offset_far_deg          <= cfg_data[7:0];
        obcdm_pkg::REG_OFFSET_NEAR:  cfg.offset_near_deg         <= cfg_data[7:0];
        obcdm_pkg::REG_HEADING_GAIN: cfg.heading_gain            <= cfg_data[6:0];
        obcdm_pkg::REG_DEADBAND:     cfg.heading_deadband_tenths <= cfg_data;
        obcdm_pkg::REG_LINE_LEVEL:   cfg.line_absent_level       <= cfg_data;
        obcdm_pkg::REG_NEAR_LEVEL:   cfg.near_ball_level         <= cfg_data;
        default: ;
      endcase
    end
  end

  // credits: samples in front or mid queue, results in back or out queue
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_cred <= '0;
      out_cred <= '0;
    end else begin
      if (accept && !mid_pop) begin
        mid_cred <= mid_cred + 1'b1;
      end else if (mid_pop && !accept) begin
        mid_cred <= mid_cred - 1'b1;
      end
      if (mid_pop && !out_pop) begin
        out_cred <= out_cred + 1'b1;
      end else if (out_pop && !mid_pop) begin
        out_cred <= out_cred - 1'b1;
      end
    end
  end

  obcdm_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .DIR_W           (DIR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .sample    (sample),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_ctl   (front_ctl),
    .out_dir   (front_dir)
  );

  assign mid_in.ctl = front_ctl;
  assign mid_in.dir = front_dir;

  obcdm_fifo #(
    .T     (mid_t),
    .DEPTH (obcdm_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (front_valid),
    .wdata (mid_in),
    .rd    (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  obcdm_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .SINE_BITS       (SINE_BITS),
    .DIR_W           (DIR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_pop),
    .in_ctl    (mid_out.ctl),
    .in_dir    (mid_out.dir),
    .cfg       (cfg),
    .out_valid (back_valid),
    .result    (back_res)
  );

  obcdm_fifo #(
    .T     (obcdm_pkg::out_t),
    .DEPTH (obcdm_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (back_valid),
    .wdata (back_res),
    .rd    (out_pop),
    .rdata (result),
    .empty (empty)
  );
endmodule

>>> bench/tb_omni_ball_chase_drive_mixer.sv
// Self-checking bench for the omni ball-chase drive mixer: random sensor samples,
// an in-bench wheel-drive predictor and random handshake stalls. Needs obcdm_pkg and the RTL.
`timescale 1ns / 1ps
module tb_omni_ball_chase_drive_mixer;

  localparam int AFB = obcdm_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int ASC = 1 << AFB;
  localparam int TURN = 360 * ASC;
  localparam int QTURN = 90 * ASC;
  localparam int CHASE_OFS = (405 * ASC) / 2;
  localparam int SF = obcdm_pkg::SINE_BITS_DEF - 1;
  localparam int LATENCY = 12;
  localparam int WATCHDOG = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  obcdm_pkg::in_t sample = '0;
  logic pop = 1'b0;
  logic empty;
  obcdm_pkg::out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  omni_ball_chase_drive_mixer uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .pop(pop), .empty(empty), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  obcdm_pkg::cfg_t regs;
  obcdm_pkg::in_t pending_samples[$];
  obcdm_pkg::out_t expected_drives[$];
  int errors = 0;
  int checked = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;     // no idling in the final stretch
  bit hold_pop = 1'b0;  // long receiver hold-off request
  int line_cnt = 0, chase_cnt = 0, other_cnt = 0;

  function automatic int qsin_deg(int k);
    int tbl[91] = '{
      0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
      5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
      11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
      16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
      21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
      25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
      28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
      30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
      32270, 32365, 32448, 32523, 32587, 32643, 32691, 32723, 32748, 32763,
      32768};
    return tbl[k];
  endfunction

  // sine in Q1.15 for an angle in 1/16 degree
  function automatic longint sine_q15(int u);
    int q, r, k, f, m;
    u = u % TURN;
    if (u < 0) u += TURN;
    q = u / QTURN;
    r = u - q * QTURN;
    if (q & 1) r = QTURN - r;
    k = r >> AFB;
    f = r & (ASC - 1);
    if (k >= 90) m = qsin_deg(90);
    else m = qsin_deg(k) + (((qsin_deg(k + 1) - qsin_deg(k)) * f + ASC / 2) >> AFB);
    return (q >= 2) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [7:0] wheel_byte(longint v_fx, int err);
    longint num, v;
    num = v_fx * 180 + longint'(err) * longint'(regs.heading_gain) * (longint'(1) << SF);
    v = num / (longint'(180) << SF);
    if (v > 127) v = 127;
    if (v < -127) v = -127;
    return (v < 0) ? (8'h80 | 8'(-v)) : 8'(v);
  endfunction

  function automatic obcdm_pkg::out_t predict_drive(obcdm_pkg::in_t s);
    int ball, prox, head, line, fw, db, dir, err, alpha;
    longint mag, x, y, n, adj;
    bit vec;
    obcdm_pkg::out_t o;
    ball = s.ball_angle; prox = s.ball_proximity; head = s.heading; line = s.line_angle;
    fw = regs.front_window_deg;
    db = regs.heading_deadband_tenths;
    mag = regs.drive_magnitude;
    x = 0; y = 0; vec = 1'b0; dir = 0;
    if (line < int'(regs.line_absent_level)) begin
      o.mode = obcdm_pkg::MODE_LINE;
      vec = 1'b1;
      dir = ((line + 180) % 360) * ASC;
    end else if (prox < int'(regs.near_ball_level) || 5 * ball < 6 * fw ||
                 (5 * ball + 6 * fw > 1800 && ball < 360)) begin
      o.mode = obcdm_pkg::MODE_CHASE;
      vec = 1'b1;
      dir = ball * ASC + CHASE_OFS;
    end else begin
      o.mode = obcdm_pkg::MODE_OTHER;
      if (ball > fw && ball < 360 - fw) begin
        // quadratic curve offset, rounded half away from zero
        n = (longint'(regs.offset_near_deg) - longint'(regs.offset_far_deg)) *
            (longint'(ball) * ball - 360 * longint'(ball)) * ASC;
        adj = (n >= 0) ? (n + 16200) / 32400 : -((-n + 16200) / 32400);
        alpha = int'(longint'(regs.offset_near_deg) * ASC + adj);
        dir = ball * ASC + (ball < 180 ? alpha : -alpha) + CHASE_OFS;
        vec = 1'b1;
      end else if (ball <= 409) begin
        x = mag << SF;
        y = mag << SF;
      end
    end
    if (vec) begin
      x = sine_q15(dir + QTURN) * mag;
      y = sine_q15(dir) * mag;
    end
    // tilt stop
    if (head > 50 && head < 310 && line > int'(regs.line_absent_level)) begin
      x = 0; y = 0;
    end
    if (head * 10 < db || head * 10 > 3600 - db) err = 0;
    else if (head < 180) err = head;
    else err = head - 360;
    o.motor_a = wheel_byte(-x, err);
    o.motor_b = wheel_byte(y, err);
    o.motor_c = wheel_byte(-y, err);
    o.motor_d = wheel_byte(x, err);
    return o;
  endfunction

  // sample driver
  int push_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_drives.push_back(predict_drive(sample));
        void'(pending_samples.pop_front());
      end
      if (push_gap > 0) begin
        push_gap <= push_gap - 1;
        push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 29) == 0) begin
        push_gap <= $urandom_range(1, 17);
        push <= 1'b0;
      end else begin
        // head of the queue is the next transaction to offer
        if (pending_samples.size() > 0) begin
          push <= 1'b1;
          sample <= pending_samples[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int pop_gap = 0;
  always @(posedge clk) begin
    obcdm_pkg::out_t exp_o;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        idle_cycles <= 0;
        if (expected_drives.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          errors++;
        end else begin
          exp_o = expected_drives.pop_front();
          checked++;
          if (result.motor_a !== exp_o.motor_a)
            $display("%0t: motor_a exp %h got %h", $time, exp_o.motor_a, result.motor_a);
          if (result.motor_b !== exp_o.motor_b)
            $display("%0t: motor_b exp %h got %h", $time, exp_o.motor_b, result.motor_b);
          if (result.motor_c !== exp_o.motor_c)
            $display("%0t: motor_c exp %h got %h", $time, exp_o.motor_c, result.motor_c);
          if (result.motor_d !== exp_o.motor_d)
            $display("%0t: motor_d exp %h got %h", $time, exp_o.motor_d, result.motor_d);
          if (result.mode !== exp_o.mode)
            $display("%0t: mode exp %0d got %0d", $time, exp_o.mode, result.mode);
          if (result !== exp_o) errors++;
          case (exp_o.mode)
            obcdm_pkg::MODE_LINE: line_cnt++;
            obcdm_pkg::MODE_CHASE: chase_cnt++;
            default: other_cnt++;
          endcase
        end
      end else if (push && !full) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (hold_pop) begin
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
        pop_gap <= $urandom_range(1, 17);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(obcdm_pkg::reg_idx_t idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      obcdm_pkg::REG_DRIVE_MAG: regs.drive_magnitude = 7'(val);
      obcdm_pkg::REG_FRONT_WIN: regs.front_window_deg = 7'(val);
      obcdm_pkg::REG_OFFSET_FAR: regs.offset_far_deg = 8'(val);
      obcdm_pkg::REG_OFFSET_NEAR: regs.offset_near_deg = 8'(val);
      obcdm_pkg::REG_HEADING_GAIN: regs.heading_gain = 7'(val);
      obcdm_pkg::REG_DEADBAND: regs.heading_deadband_tenths = 10'(val);
      obcdm_pkg::REG_LINE_LEVEL: regs.line_absent_level = 10'(val);
      obcdm_pkg::REG_NEAR_LEVEL: regs.near_ball_level = 10'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_drives.size() > 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic obcdm_pkg::in_t make_sample(int b, int p, int h, int l);
    obcdm_pkg::in_t s;
    s.ball_angle = 10'(b); s.ball_proximity = 10'(p);
    s.heading = 10'(h); s.line_angle = 10'(l);
    return s;
  endfunction

  // mostly no line and far ball, some headings near zero, to reach the curve path
  function automatic obcdm_pkg::in_t random_sample();
    int sel;
    obcdm_pkg::in_t s;
    sel = $urandom_range(0, 9);
    s = make_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023));
    if (sel < 6) begin
      s.ball_angle = 10'($urandom_range(0, 420));
      s.ball_proximity = 10'($urandom_range(regs.near_ball_level, 1023));
      s.line_angle = 10'($urandom_range(regs.line_absent_level, 1023));
      if (sel < 4) s.heading = ($urandom_range(0, 1)) ? 10'($urandom_range(0, 60))
                                                      : 10'($urandom_range(300, 359));
    end
    return s;
  endfunction

  task automatic run_random(int count);
    repeat (count) pending_samples.push_back(random_sample());
  endtask

  initial begin
    regs = '{drive_magnitude: 80, front_window_deg: 10, offset_far_deg: 70,
             offset_near_deg: 30, heading_gain: 15, heading_deadband_tenths: 25,
             line_absent_level: 400, near_ball_level: 500};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // directed: line escape, chase window, curve, straight, stop, tilt stop, extremes
    pending_samples.push_back(make_sample(0, 1023, 0, 0));
    pending_samples.push_back(make_sample(1023, 1023, 1023, 1023));
    pending_samples.push_back(make_sample(100, 0, 0, 1023));
    pending_samples.push_back(make_sample(11, 1023, 0, 1023));
    pending_samples.push_back(make_sample(355, 1023, 0, 1023));
    pending_samples.push_back(make_sample(90, 1023, 0, 1023));
    pending_samples.push_back(make_sample(270, 1023, 0, 1023));
    pending_samples.push_back(make_sample(180, 1023, 0, 1023));
    pending_samples.push_back(make_sample(400, 1023, 0, 1023));
    pending_samples.push_back(make_sample(409, 1023, 0, 1023));
    pending_samples.push_back(make_sample(410, 1023, 0, 1023));
    pending_samples.push_back(make_sample(360, 1023, 0, 1023));
    pending_samples.push_back(make_sample(200, 1023, 100, 1023));
    pending_samples.push_back(make_sample(200, 1023, 100, 400));
    pending_samples.push_back(make_sample(200, 1023, 2, 1023));
    pending_samples.push_back(make_sample(200, 1023, 3, 1023));
    pending_samples.push_back(make_sample(200, 1023, 358, 1023));
    pending_samples.push_back(make_sample(200, 1023, 180, 1023));
    pending_samples.push_back(make_sample(200, 1023, 179, 1023));
    pending_samples.push_back(make_sample(200, 1023, 310, 399));
    pending_samples.push_back(make_sample(200, 1023, 51, 359));
    pending_samples.push_back(make_sample(200, 1023, 50, 1023));
    pending_samples.push_back(make_sample(1, 1023, 0, 1023));
    drain();

    run_random(150);
    // receiver hold-off while the sender keeps offering
    hold_pop = 1'b1;
    repeat (200) @(posedge clk);
    hold_pop = 1'b0;
    drain();

    // extremes
    write_reg(obcdm_pkg::REG_DRIVE_MAG, 127);
    write_reg(obcdm_pkg::REG_FRONT_WIN, 90);
    write_reg(obcdm_pkg::REG_OFFSET_FAR, 180);
    write_reg(obcdm_pkg::REG_OFFSET_NEAR, 0);
    write_reg(obcdm_pkg::REG_HEADING_GAIN, 127);
    write_reg(obcdm_pkg::REG_DEADBAND, 900);
    write_reg(obcdm_pkg::REG_LINE_LEVEL, 1023);
    write_reg(obcdm_pkg::REG_NEAR_LEVEL, 0);
    run_random(150);
    drain();

    write_reg(obcdm_pkg::REG_DRIVE_MAG, 0);
    write_reg(obcdm_pkg::REG_FRONT_WIN, 0);
    write_reg(obcdm_pkg::REG_OFFSET_FAR, 0);
    write_reg(obcdm_pkg::REG_OFFSET_NEAR, 180);
    write_reg(obcdm_pkg::REG_HEADING_GAIN, 0);
    write_reg(obcdm_pkg::REG_DEADBAND, 0);
    write_reg(obcdm_pkg::REG_LINE_LEVEL, 0);
    write_reg(obcdm_pkg::REG_NEAR_LEVEL, 1023);
    run_random(120);
    drain();

    // mid settings, several random draws
    repeat (3) begin
      write_reg(obcdm_pkg::REG_DRIVE_MAG, $urandom_range(0, 127));
      write_reg(obcdm_pkg::REG_FRONT_WIN, $urandom_range(0, 90));
      write_reg(obcdm_pkg::REG_OFFSET_FAR, $urandom_range(0, 180));
      write_reg(obcdm_pkg::REG_OFFSET_NEAR, $urandom_range(0, 180));
      write_reg(obcdm_pkg::REG_HEADING_GAIN, $urandom_range(0, 127));
      write_reg(obcdm_pkg::REG_DEADBAND, $urandom_range(0, 900));
      write_reg(obcdm_pkg::REG_LINE_LEVEL, $urandom_range(0, 1023));
      write_reg(obcdm_pkg::REG_NEAR_LEVEL, $urandom_range(0, 1023));
      run_random(110);
      drain();
    end

    // final stretch with no idling
    quiet = 1'b1;
    run_random(80);
    drain();

    $display("Checked %0d results: %0d line escape, %0d chase, %0d curve/straight/stop,",
             checked, line_cnt, chase_cnt, other_cnt);
    $display("over default, extreme and random register settings with stalls.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
